### sv/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes for the indexed list engine: request kinds,
// result status codes and field widths.
// ----------------------------------------------------------------------------
package ile_pkg;

    // field widths of the stream payloads
    localparam int ACTION_W = 3;
    localparam int POS_W    = 11;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 11;

    // packed payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((ACTION_W + POS_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + STATUS_W + LEN_W + 7) / 8) * 8;

    // request kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_READ      = 3'd0,
        ACT_INS_HEAD  = 3'd1,
        ACT_APPEND    = 3'd2,
        ACT_INS_AT    = 3'd3,
        ACT_DELETE    = 3'd4
    } t_action;

    // result status
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // read value returned whenever no entry is read
    localparam logic signed [VALUE_W-1:0] NO_VALUE = -32'sd1;

endpackage

### sv/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data, read-before-write.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/indexed_list_engine_core.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Ordered list of up to CAPACITY signed 32-bit words kept in one RAM, with
// read, insert at head, append, insert at position and delete requests.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s-side stream, one per transfer; each gives exactly
//   one result on the m-side stream (read value, status, length after).
//   Entries live in a RAM with one read and one write port and a registered
//   read. Insert and delete move the entries above the position one place per
//   cycle through that RAM (read one entry, write it back one slot over).
//   In-range reads, and inserts or deletes that move entries, pass through the
//   S_RD, S_UP and S_FIN, or S_DOWN states before the result; inserts at the
//   tail (append, head into an empty list), deletes of the last entry, range
//   errors, a full list and unknown kinds give their result straight from idle.
//   One request is worked on at a time; the next is taken once the engine is
//   back in idle and the result register is free or being drained.
//   A stalled receiver holds the result in the output register and stops
//   new requests. Reset empties the list at once; RAM contents are not
//   cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_engine_core
    import ile_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request: action [2:0], position [13:3], value [45:14], zero pad above
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // result: read_value [31:0], status [33:32], length [44:34], zero pad above
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UP,
        S_FIN,
        S_DOWN
    } t_state;

    // request fields
    logic [ACTION_W-1:0]      w_action;
    logic [POS_W-1:0]         w_pos;
    logic [VALUE_W-1:0]       w_value;

    assign w_action = i_s_tdata[ACTION_W-1:0];
    assign w_pos    = i_s_tdata[ACTION_W +: POS_W];
    assign w_value  = i_s_tdata[ACTION_W+POS_W +: VALUE_W];

    // control and result registers
    t_state                   r_state,  n_state;
    logic [CW-1:0]            r_count,  n_count;
    logic [AW-1:0]            r_idx,    n_idx;
    logic [AW-1:0]            r_pos,    n_pos;
    logic [VALUE_W-1:0]       r_val,    n_val;
    logic                     r_ovalid, n_ovalid;
    logic [VALUE_W-1:0]       r_orval,  n_orval;
    t_status                  r_ostat,  n_ostat;
    logic [LEN_W-1:0]         r_olen,   n_olen;

    // ram ports
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [VALUE_W-1:0]       w_wdata;
    logic                     w_re;
    logic [AW-1:0]            w_raddr;
    logic [VALUE_W-1:0]       w_rdata;

    logic                     w_accept;
    logic [CMPW-1:0]          w_pos_x;
    logic [CMPW-1:0]          w_cnt_x;
    logic [CMPW-1:0]          w_ins_x;
    logic                     w_do_ins;

    assign o_s_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_pos_x    = CMPW'(w_pos);
    assign w_cnt_x    = CMPW'(r_count);

    ile_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // request decode and shift sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_val    = r_val;
        n_ovalid = r_ovalid && !i_m_tready;
        n_orval  = r_orval;
        n_ostat  = r_ostat;
        n_olen   = r_olen;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = w_rdata;
        w_re     = 1'b0;
        w_raddr  = r_idx;
        w_ins_x  = '0;
        w_do_ins = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_action'(w_action))
                        ACT_READ: begin
                            if (w_pos_x < w_cnt_x) begin
                                w_re    = 1'b1;
                                w_raddr = w_pos_x[AW-1:0];
                                n_state = S_RD;
                            end else begin
                                n_ovalid = 1'b1;
                                n_orval  = NO_VALUE;
                                n_ostat  = ST_RANGE;
                                n_olen   = LEN_W'(r_count);
                            end
                        end
                        ACT_INS_HEAD: begin
                            w_ins_x  = '0;
                            w_do_ins = 1'b1;
                        end
                        ACT_APPEND: begin
                            w_ins_x  = w_cnt_x;
                            w_do_ins = 1'b1;
                        end
                        ACT_INS_AT: begin
                            if (w_pos_x > w_cnt_x) begin
                                n_ovalid = 1'b1;
                                n_orval  = NO_VALUE;
                                n_ostat  = ST_RANGE;
                                n_olen   = LEN_W'(r_count);
                            end else begin
                                w_ins_x  = w_pos_x;
                                w_do_ins = 1'b1;
                            end
                        end
                        ACT_DELETE: begin
                            if (w_pos_x < w_cnt_x) begin
                                if (w_pos_x == w_cnt_x - CMPW'(1)) begin
                                    // last entry: nothing to move
                                    n_count  = r_count - CW'(1);
                                    n_ovalid = 1'b1;
                                    n_orval  = NO_VALUE;
                                    n_ostat  = ST_DONE;
                                    n_olen   = LEN_W'(r_count - CW'(1));
                                end else begin
                                    w_re    = 1'b1;
                                    w_raddr = w_pos_x[AW-1:0] + AW'(1);
                                    n_idx   = w_pos_x[AW-1:0] + AW'(1);
                                    n_pos   = w_pos_x[AW-1:0];
                                    n_state = S_DOWN;
                                end
                            end else begin
                                n_ovalid = 1'b1;
                                n_orval  = NO_VALUE;
                                n_ostat  = ST_RANGE;
                                n_olen   = LEN_W'(r_count);
                            end
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_orval  = NO_VALUE;
                            n_ostat  = ST_RANGE;
                            n_olen   = LEN_W'(r_count);
                        end
                    endcase

                    // common insert path
                    if (w_do_ins) begin
                        if (r_count == FULL_COUNT) begin
                            n_ovalid = 1'b1;
                            n_orval  = NO_VALUE;
                            n_ostat  = ST_FULL;
                            n_olen   = LEN_W'(r_count);
                        end else if (w_ins_x == w_cnt_x) begin
                            // insert at the tail: single write
                            w_we     = 1'b1;
                            w_waddr  = w_cnt_x[AW-1:0];
                            w_wdata  = w_value;
                            n_count  = r_count + CW'(1);
                            n_ovalid = 1'b1;
                            n_orval  = NO_VALUE;
                            n_ostat  = ST_DONE;
                            n_olen   = LEN_W'(r_count + CW'(1));
                        end else begin
                            // move entries up starting at the top one
                            w_re    = 1'b1;
                            w_raddr = w_cnt_x[AW-1:0] - AW'(1);
                            n_idx   = w_cnt_x[AW-1:0] - AW'(1);
                            n_pos   = w_ins_x[AW-1:0];
                            n_val   = w_value;
                            n_state = S_UP;
                        end
                    end
                end
            end
            S_RD: begin
                n_ovalid = 1'b1;
                n_orval  = w_rdata;
                n_ostat  = ST_DONE;
                n_olen   = LEN_W'(r_count);
                n_state  = S_IDLE;
            end
            S_UP: begin
                // entry read last cycle moves one place up
                w_we    = 1'b1;
                w_waddr = r_idx + AW'(1);
                w_wdata = w_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_FIN;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end
            S_FIN: begin
                w_we     = 1'b1;
                w_waddr  = r_pos;
                w_wdata  = r_val;
                n_count  = r_count + CW'(1);
                n_ovalid = 1'b1;
                n_orval  = NO_VALUE;
                n_ostat  = ST_DONE;
                n_olen   = LEN_W'(r_count + CW'(1));
                n_state  = S_IDLE;
            end
            S_DOWN: begin
                // entry read last cycle moves one place down
                w_we    = 1'b1;
                w_waddr = r_idx - AW'(1);
                w_wdata = w_rdata;
                if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_count  = r_count - CW'(1);
                    n_ovalid = 1'b1;
                    n_orval  = NO_VALUE;
                    n_ostat  = ST_DONE;
                    n_olen   = LEN_W'(r_count - CW'(1));
                    n_state  = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_orval <= n_orval;
        r_ostat <= n_ostat;
        r_olen  <= n_olen;
    end

    // result stream
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_DATA_W-VALUE_W-STATUS_W-LEN_W){1'b0}},
                         r_olen, r_ostat, r_orval};

    // count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above capacity");

    // upward move stays between insert point and top entry
    a_up_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (r_idx >= r_pos) && (CW'(r_idx) < r_count))
        else $error("insert move index out of window");

    // downward move stays above the deleted entry and inside the list
    a_down_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOWN) |-> (r_idx > r_pos) && (CW'(r_idx) < r_count))
        else $error("delete move index out of window");

    // result register is free whenever a request is in flight
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ovalid)
        else $error("result pending while request busy");

    // an insert finish grows the list by one and raises the result
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_count == $past(r_count) + CW'(1)) && r_ovalid)
        else $error("insert finish did not grow list");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for indexed_list_engine_core. A short table of
// requests covers the empty list, the value extremes, every request kind and
// the range cases. Random traffic follows, mostly well-formed requests on a
// short list, with some requests out of range and some unknown kinds. A last
// phase fills the list to capacity, checks the list-full case and works near
// the tail. Each result is checked against a bit-true bench list or a typed-in result.
// ----------------------------------------------------------------------------
module tb;
    import ile_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam longint TIMEOUT_NS = 80_000_000;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int PHASE_ITEMS  = 70;
    localparam int NEAR_FULL_ITEMS = 120;
    localparam int SHORT_LEN    = 48;
    localparam int TAIL_SPAN    = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;
    localparam int PAD_W        = IN_DATA_W - ACTION_W - POS_W - VALUE_W;

    // request kinds the block does not know
    localparam logic [ACTION_W-1:0] ACT_BAD_LO  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_BAD_MID = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_BAD_HI  = 3'd7;

    // value extremes
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        t_status                   status;
        logic [LEN_W-1:0]          length;
    } list_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       act;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
        logic                      fixed;
        list_result_t              res;
    } dir_row_t;

    localparam list_result_t NO_RES = '0;

    // directed requests; typed-in results only where they are plain
    localparam int DIR_N = 24;
    localparam dir_row_t DIR_TBL [DIR_N] = '{
        '{ACT_READ,     11'd0,    32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_DELETE,   11'd0,    32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_INS_AT,   11'd1,    32'sd5,       1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_BAD_LO,   11'd2047, -32'sd1,      1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_BAD_MID,  11'd0,    32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_BAD_HI,   11'd1024, VAL_MAX,      1'b1, '{NO_VALUE, ST_RANGE, 11'd0}},
        '{ACT_APPEND,   11'd2047, VAL_MAX,      1'b1, '{NO_VALUE, ST_DONE,  11'd1}},
        '{ACT_INS_HEAD, 11'd0,    VAL_MIN,      1'b1, '{NO_VALUE, ST_DONE,  11'd2}},
        '{ACT_READ,     11'd0,    -32'sd1,      1'b1, '{VAL_MIN,  ST_DONE,  11'd2}},
        '{ACT_READ,     11'd1,    32'sd0,       1'b1, '{VAL_MAX,  ST_DONE,  11'd2}},
        '{ACT_READ,     11'd2,    32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd2}},
        '{ACT_READ,     11'd2047, 32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd2}},
        '{ACT_INS_AT,   11'd2,    32'sd0,       1'b1, '{NO_VALUE, ST_DONE,  11'd3}},
        '{ACT_INS_AT,   11'd1,    32'sh5555AAAA, 1'b0, NO_RES},
        '{ACT_INS_AT,   11'd5,    32'sd7,       1'b1, '{NO_VALUE, ST_RANGE, 11'd4}},
        '{ACT_INS_AT,   11'd0,    32'shAAAA5555, 1'b0, NO_RES},
        '{ACT_READ,     11'd4,    32'sd0,       1'b0, NO_RES},
        '{ACT_DELETE,   11'd5,    32'sd0,       1'b1, '{NO_VALUE, ST_RANGE, 11'd5}},
        '{ACT_DELETE,   11'd4,    32'sd0,       1'b0, NO_RES},
        '{ACT_DELETE,   11'd0,    32'sd0,       1'b0, NO_RES},
        '{ACT_DELETE,   11'd1,    32'sd0,       1'b0, NO_RES},
        '{ACT_READ,     11'd1,    32'sd0,       1'b0, NO_RES},
        '{ACT_INS_HEAD, 11'd1535, -32'sd1,      1'b0, NO_RES},
        '{ACT_READ,     11'd0,    32'sd0,       1'b0, NO_RES}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // request: action, position, value, zero pad
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // result: read_value, status, length, zero pad
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // bench copy of the list
    logic signed [VALUE_W-1:0] list_words [CAPACITY];
    int                        list_len = 0;

    list_result_t expected_results [$];
    int mismatch_cnt = 0;
    int snd_idle_pct = 8;
    int rcv_idle_pct = 63;
    int hold_reqs    = 0;

    indexed_list_engine_core #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // insert into the bench list, range checked before capacity
    function automatic t_status list_insert(int at, logic signed [VALUE_W-1:0] val);
        int p;
        if (at > list_len) return ST_RANGE;
        if (list_len >= CAPACITY) return ST_FULL;
        for (p = list_len; p > at; p--) list_words[p] = list_words[p-1];
        list_words[at] = val;
        list_len++;
        return ST_DONE;
    endfunction

    // apply one request to the bench list and return its result
    function automatic list_result_t list_apply(logic [ACTION_W-1:0] act,
                                                logic [POS_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] val);
        list_result_t r;
        int p;
        r.read_value = NO_VALUE;
        r.status     = ST_DONE;
        case (act)
            ACT_READ: begin
                if (int'(pos) < list_len) r.read_value = list_words[pos];
                else r.status = ST_RANGE;
            end
            ACT_INS_HEAD: r.status = list_insert(0, val);
            ACT_APPEND:   r.status = list_insert(list_len, val);
            ACT_INS_AT:   r.status = list_insert(int'(pos), val);
            ACT_DELETE: begin
                if (int'(pos) < list_len) begin
                    for (p = int'(pos); p < list_len - 1; p++) list_words[p] = list_words[p+1];
                    list_len--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.length = list_len[LEN_W-1:0];
        return r;
    endfunction

    // random word, extremes now and then
    function automatic logic signed [VALUE_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // offer one request, starting and ending at a falling edge
    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [POS_W-1:0] pos,
                             input logic signed [VALUE_W-1:0] val,
                             input logic fixed = 1'b0,
                             input list_result_t fixed_res = '0);
        list_result_t exp;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{PAD_W{1'b0}}, val, pos, act};
        do @(posedge i_clk); while (!o_s_tready);
        exp = list_apply(act, pos, val);
        if (fixed) exp = fixed_res;
        expected_results.push_back(exp);
        @(negedge i_clk);
    endtask

    // random request; tail_span > 0 keeps positions near the tail
    task automatic send_random(input int len_cap, input int tail_span);
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        int r;
        int span;
        span = (tail_span > 0 && tail_span < list_len) ? tail_span : list_len;
        pos  = POS_W'($urandom_range(POS_MAX));
        r    = $urandom_range(99);
        if (r < 3) begin
            act = 3'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
        end else if (r < 9) begin
            // positions out of range
            case ($urandom_range(2))
                0: begin
                    act = ACT_READ;
                    pos = POS_W'($urandom_range(POS_MAX, list_len));
                end
                1: begin
                    act = ACT_DELETE;
                    pos = POS_W'($urandom_range(POS_MAX, list_len));
                end
                default: begin
                    act = ACT_INS_AT;
                    pos = POS_W'($urandom_range(POS_MAX, list_len + 1));
                end
            endcase
        end else begin
            r = $urandom_range(99);
            if (list_len == 0) r = 60 + r % 40;
            else if (list_len >= len_cap && r >= 50 && r < 90) r = 35 + r % 15;
            if (r < 35) begin
                act = ACT_READ;
                pos = POS_W'(list_len - 1 - $urandom_range(span - 1));
            end else if (r < 50) begin
                act = ACT_DELETE;
                pos = POS_W'(list_len - 1 - $urandom_range(span - 1));
            end else if (r < 62) begin
                act = (tail_span > 0) ? ACT_APPEND : ACT_INS_HEAD;
            end else if (r < 80) begin
                act = ACT_APPEND;
            end else begin
                act = ACT_INS_AT;
                pos = POS_W'(list_len - $urandom_range(span));
            end
        end
        send_item(act, pos, rand_word());
    endtask

    // stop offering until every result is back, then set the idle rates
    task automatic drain_and_set(input int snd_pct, input int rcv_pct, input bit hold);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        if (hold) hold_reqs++;
        @(negedge i_clk);
    endtask

    // receiver: random stalls, long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // check each result transfer against the oldest expected result
    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t exp;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.read_value = o_m_tdata[31:0];
            got.status     = t_status'(o_m_tdata[33:32]);
            got.length     = o_m_tdata[44:34];
            if (expected_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: unexpected result rd=%0d st=%0d len=%0d",
                             $realtime, got.read_value, got.status, got.length);
            end else begin
                exp = expected_results.pop_front();
                if (got.read_value !== exp.read_value || got.status !== exp.status ||
                    got.length !== exp.length) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: mismatch exp rd=%0d st=%0d len=%0d got rd=%0d st=%0d len=%0d",
                                 $realtime, exp.read_value, exp.status, exp.length,
                                 got.read_value, got.status, got.length);
                end
            end
        end
    end

    // stimulus
    initial begin
        int i;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (i = 0; i < DIR_N; i++)
            send_item(DIR_TBL[i].act, DIR_TBL[i].pos, DIR_TBL[i].val,
                      DIR_TBL[i].fixed, DIR_TBL[i].res);

        // short list, sender rarely idle, receiver often stalled
        for (i = 0; i < PHASE_ITEMS; i++) send_random(SHORT_LEN, 0);

        // the other way round
        drain_and_set(63, 8, 1'b0);
        for (i = 0; i < PHASE_ITEMS; i++) send_random(SHORT_LEN, 0);

        // no idling, opened by a long receiver hold-off
        drain_and_set(0, 0, 1'b1);
        for (i = 0; i < PHASE_ITEMS; i++) send_random(SHORT_LEN, 0);

        // fill to capacity, mostly at the tail
        drain_and_set(0, 0, 1'b0);
        while (list_len < CAPACITY) begin
            case ($urandom_range(9))
                0, 1: send_item(ACT_INS_AT,
                                POS_W'(list_len - $urandom_range(list_len < 3 ? list_len : 3)),
                                rand_word());
                2: begin
                    if (list_len > 0)
                        send_item(ACT_READ, POS_W'($urandom_range(list_len - 1)), rand_word());
                    else
                        send_item(ACT_APPEND, POS_W'($urandom_range(POS_MAX)), rand_word());
                end
                3: begin
                    if (list_len < SHORT_LEN) send_item(ACT_INS_HEAD, 11'd0, rand_word());
                    else send_item(ACT_APPEND, 11'd0, rand_word());
                end
                default: send_item(ACT_APPEND, POS_W'($urandom_range(POS_MAX)), rand_word());
            endcase
        end

        // full list: inserts dropped, range still checked first
        send_item(ACT_INS_HEAD, 11'd0, rand_word());
        send_item(ACT_APPEND, 11'd0, rand_word());
        send_item(ACT_INS_AT, 11'd1024, rand_word());
        send_item(ACT_INS_AT, 11'd0, rand_word());
        send_item(ACT_INS_AT, 11'd1025, rand_word());
        send_item(ACT_INS_AT, 11'd2047, rand_word());
        send_item(ACT_READ, 11'd1023, rand_word());
        send_item(ACT_READ, 11'd1024, rand_word());
        send_item(ACT_DELETE, 11'd1024, rand_word());
        send_item(ACT_BAD_HI, 11'd1023, rand_word());

        // a few long moves across the whole list
        send_item(ACT_DELETE, 11'd0, rand_word());
        send_item(ACT_INS_AT, 11'd0, rand_word());
        send_item(ACT_READ, 11'd0, rand_word());
        send_item(ACT_DELETE, 11'd511, rand_word());
        send_item(ACT_INS_HEAD, 11'd0, rand_word());
        send_item(ACT_READ, 11'd512, rand_word());

        // near-full traffic at the tail, receiver stalls again
        drain_and_set(8, 63, 1'b0);
        for (i = 0; i < NEAR_FULL_ITEMS; i++) send_random(CAPACITY, TAIL_SPAN);

        drain_and_set(0, 0, 1'b0);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
